// ===== rtl/core/axis_angle_frame_transform_unit_macros.svh =====
// assertion macros for the checker file of the frame transform unit
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef AXIS_ANGLE_FRAME_TRANSFORM_UNIT_MACROS_SVH
`define AXIS_ANGLE_FRAME_TRANSFORM_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AAFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define AAFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/aaft_pkg.sv =====
// shared types, constants and functions of the axis-angle frame transform unit
// no dependencies
package aaft_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned AxisW     = 18;
  localparam int unsigned AngleW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned PipeDepth = 8;
  localparam logic [63:0] PiHalfQ30 = 64'd1686629713;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_AXIS_X     = 3'd3,
    CFG_AXIS_Y     = 3'd4,
    CFG_AXIS_Z     = 3'd5,
    CFG_TURN_ANGLE = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_TO_LOCAL  = 1'b0,
    OP_TO_GLOBAL = 1'b1
  } opcode_e;

  typedef struct packed {
    logic                     opcode;
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     saturated;
  } rsp_t;

  // floor(v / 2^16 + 1/2)
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  // sine over a quarter turn, r in 1/65536 turn units (0..16384), Q1.16
  // only ever evaluated on constants when the table is built
  function automatic logic [16:0] quarter_sin(input logic [14:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    x    = ({49'd0, r} * PiHalfQ30) >> 14;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    q    = (unsigned'(sum) + 64'd8192) >> 14;
    return (q > 64'd65536) ? 17'd65536 : q[16:0];
  endfunction

endpackage

// ===== rtl/core/aaft_stream_if.sv =====
// valid/ready stream interfaces for points in and transformed points out
// depends on aaft_pkg
interface aaft_req_if import aaft_pkg::*;;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aaft_rsp_if import aaft_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/axis_angle_frame_transform_unit.sv =====
// Axis-angle frame transform: a fully pipelined unit that takes one point per
// clock unless a stalled output has filled the pipe, and returns its transformed
// point through eight register stages of multipliers, rounders and adders (the
// last stage is the output register). A stalled output holds the pipe only as far back as it is full.
// Sine and cosine come from a quarter-wave table of 2^(TRIG_TABLE_BITS-2)+1
// entries built at elaboration. Configuration is read live by the stages, so
// write it only while no point is in flight.
module axis_angle_frame_transform_unit import aaft_pkg::*; #(
  parameter int unsigned TRIG_TABLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  aaft_req_if.sink            req_i,
  aaft_rsp_if.source          rsp_o
);

  localparam int unsigned Qb = TRIG_TABLE_BITS - 2;
  localparam int unsigned Qn = 1 << Qb;
  localparam int unsigned Sh = AngleW - TRIG_TABLE_BITS;
  localparam logic signed [43:0] MaxV = 44'sd2147483647;
  localparam logic signed [43:0] MinV = -44'sd2147483648;

  // configuration registers
  logic signed [CoordW-1:0] origin_q [3];
  logic signed [AxisW-1:0]  axis_q   [3];
  logic [AngleW-1:0]        angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) origin_q[i] <= '0;
      axis_q[0] <= '0;
      axis_q[1] <= '0;
      axis_q[2] <= 18'sd65536;
      angle_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:   origin_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y:   origin_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z:   origin_q[2] <= cfg_data_i;
        CFG_AXIS_X:     axis_q[0]   <= cfg_data_i[AxisW-1:0];
        CFG_AXIS_Y:     axis_q[1]   <= cfg_data_i[AxisW-1:0];
        CFG_AXIS_Z:     axis_q[2]   <= cfg_data_i[AxisW-1:0];
        CFG_TURN_ANGLE: angle_q     <= cfg_data_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine table, one entry per table step plus the peak
  logic [16:0] qtab [Qn+1];
  for (genvar g = 0; g <= Qn; g++) begin : g_tab
    assign qtab[g] = quarter_sin(15'(g << Sh));
  end

  // table lookup for sine and cosine of the truncated angle
  logic [TRIG_TABLE_BITS-1:0] ks, kc;
  logic [Qb:0]                sidx, cidx;
  logic signed [17:0]         sin_val, cos_val;

  always_comb begin
    ks = angle_q[AngleW-1 -: TRIG_TABLE_BITS];
    kc = ks + TRIG_TABLE_BITS'(Qn);
    sidx = ks[Qb] ? ((Qb+1)'(Qn) - {1'b0, ks[Qb-1:0]}) : {1'b0, ks[Qb-1:0]};
    cidx = kc[Qb] ? ((Qb+1)'(Qn) - {1'b0, kc[Qb-1:0]}) : {1'b0, kc[Qb-1:0]};
    sin_val = ks[Qb+1] ? -signed'({1'b0, qtab[sidx]}) : signed'({1'b0, qtab[sidx]});
    cos_val = kc[Qb+1] ? -signed'({1'b0, qtab[cidx]}) : signed'({1'b0, qtab[cidx]});
  end

  // stage handshake: a stage loads when it is empty or the next one moves
  logic [PipeDepth:1] v_q;
  logic [PipeDepth:1] en;

  always_comb begin
    en[PipeDepth] = rsp_o.ready | ~v_q[PipeDepth];
    for (int k = PipeDepth - 1; k >= 1; k--) en[k] = ~v_q[k] | en[k+1];
  end

  assign req_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= req_i.valid;
      for (int k = 2; k <= PipeDepth; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: origin offset for a to-local point, and trig
  logic               s1_inv_q;
  logic signed [32:0] s1_d_q [3];
  logic signed [17:0] s1_s_q, s1_c_q;
  logic               req_inv;

  assign req_inv = (opcode_e'(req_i.data.opcode) == OP_TO_GLOBAL);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_inv_q <= req_inv;
      s1_s_q   <= req_inv ? -sin_val : sin_val;
      s1_c_q   <= cos_val;
      s1_d_q[0] <= req_inv ? 33'(req_i.data.in_x) : 33'(req_i.data.in_x) - 33'(origin_q[0]);
      s1_d_q[1] <= req_inv ? 33'(req_i.data.in_y) : 33'(req_i.data.in_y) - 33'(origin_q[1]);
      s1_d_q[2] <= req_inv ? 33'(req_i.data.in_z) : 33'(req_i.data.in_z) - 33'(origin_q[2]);
    end
  end

  // stage 2: all nine d*u products
  logic               s2_inv_q;
  logic signed [32:0] s2_d_q [3];
  logic signed [17:0] s2_s_q, s2_c_q;
  logic signed [50:0] s2_p_q [9];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_inv_q <= s1_inv_q;
      s2_s_q   <= s1_s_q;
      s2_c_q   <= s1_c_q;
      for (int i = 0; i < 3; i++) begin
        s2_d_q[i] <= s1_d_q[i];
        for (int j = 0; j < 3; j++) begin
          s2_p_q[i*3+j] <= 51'(s1_d_q[i]) * 51'(axis_q[j]);
        end
      end
    end
  end

  // stage 3: dot and cross products, rounded
  logic               s3_inv_q;
  logic signed [32:0] s3_d_q [3];
  logic signed [17:0] s3_s_q, s3_c_q;
  logic signed [36:0] s3_dot_q;
  logic signed [35:0] s3_cr_q [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_inv_q <= s2_inv_q;
      s3_s_q   <= s2_s_q;
      s3_c_q   <= s2_c_q;
      for (int i = 0; i < 3; i++) s3_d_q[i] <= s2_d_q[i];
      s3_dot_q <= 37'(rnd16(64'(s2_p_q[0]) + 64'(s2_p_q[4]) + 64'(s2_p_q[8])));
      s3_cr_q[0] <= 36'(rnd16(64'(s2_p_q[5]) - 64'(s2_p_q[7])));
      s3_cr_q[1] <= 36'(rnd16(64'(s2_p_q[6]) - 64'(s2_p_q[2])));
      s3_cr_q[2] <= 36'(rnd16(64'(s2_p_q[1]) - 64'(s2_p_q[3])));
    end
  end

  // stage 4: axis term, cosine term and sine term products
  logic               s4_inv_q;
  logic signed [17:0] s4_c_q;
  logic signed [54:0] s4_mt_q  [3];
  logic signed [50:0] s4_mdc_q [3];
  logic signed [53:0] s4_mcs_q [3];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_inv_q <= s3_inv_q;
      s4_c_q   <= s3_c_q;
      for (int i = 0; i < 3; i++) begin
        s4_mt_q[i]  <= 55'(axis_q[i]) * 55'(s3_dot_q);
        s4_mdc_q[i] <= 51'(s3_d_q[i]) * 51'(s3_c_q);
        s4_mcs_q[i] <= 54'(s3_cr_q[i]) * 54'(s3_s_q);
      end
    end
  end

  // stage 5: round the products, form 1 - cos
  logic               s5_inv_q;
  logic signed [18:0] s5_omc_q;
  logic signed [38:0] s5_t_q  [3];
  logic signed [34:0] s5_dc_q [3];
  logic signed [37:0] s5_cs_q [3];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_inv_q <= s4_inv_q;
      s5_omc_q <= 19'sd65536 - 19'(s4_c_q);
      for (int i = 0; i < 3; i++) begin
        s5_t_q[i]  <= 39'(rnd16(64'(s4_mt_q[i])));
        s5_dc_q[i] <= 35'(rnd16(64'(s4_mdc_q[i])));
        s5_cs_q[i] <= 38'(rnd16(64'(s4_mcs_q[i])));
      end
    end
  end

  // stage 6: axis term times 1 - cos
  logic               s6_inv_q;
  logic signed [57:0] s6_mto_q [3];
  logic signed [34:0] s6_dc_q  [3];
  logic signed [37:0] s6_cs_q  [3];

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_inv_q <= s5_inv_q;
      for (int i = 0; i < 3; i++) begin
        s6_mto_q[i] <= 58'(s5_t_q[i]) * 58'(s5_omc_q);
        s6_dc_q[i]  <= s5_dc_q[i];
        s6_cs_q[i]  <= s5_cs_q[i];
      end
    end
  end

  // stage 7: round axis term, sum the rest with the origin on the way back
  logic signed [41:0] s7_to_q   [3];
  logic signed [43:0] s7_part_q [3];

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        s7_to_q[i]   <= 42'(rnd16(64'(s6_mto_q[i])));
        s7_part_q[i] <= 44'(s6_dc_q[i]) + 44'(s6_cs_q[i])
                      + (s6_inv_q ? 44'(origin_q[i]) : 44'sd0);
      end
    end
  end

  // stage 8: final sum and clip, the output register
  logic signed [43:0]       sum_v [3];
  logic signed [CoordW-1:0] clip_v [3];
  logic [2:0]               sat_v;
  rsp_t                     s8_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_v[i] = 44'(s7_to_q[i]) + s7_part_q[i];
      sat_v[i] = 1'b0;
      if (sum_v[i] > MaxV) begin
        clip_v[i] = MaxV[CoordW-1:0];
        sat_v[i]  = 1'b1;
      end else if (sum_v[i] < MinV) begin
        clip_v[i] = MinV[CoordW-1:0];
        sat_v[i]  = 1'b1;
      end else begin
        clip_v[i] = sum_v[i][CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_q.out_x     <= clip_v[0];
      s8_q.out_y     <= clip_v[1];
      s8_q.out_z     <= clip_v[2];
      s8_q.saturated <= |sat_v;
    end
  end

  assign rsp_o.valid = v_q[PipeDepth];
  assign rsp_o.data  = s8_q;

endmodule

// ===== rtl/core/aaft_checker.sv =====
// port-level checks for the frame transform unit, bound to the top level
// depends on aaft_pkg and the assertion macro header
`include "axis_angle_frame_transform_unit_macros.svh"

module aaft_checker import aaft_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  localparam int unsigned CntW = $clog2(PipeDepth + 2);
  localparam logic signed [CoordW-1:0] MaxC = 32'sh7fffffff;
  localparam logic signed [CoordW-1:0] MinC = 32'sh80000000;

  // requests accepted but not yet delivered
  logic [CntW-1:0] inflight_q, inflight_d;
  logic            acc, del;

  assign acc = req_valid_i & req_ready_i;
  assign del = rsp_valid_i & rsp_ready_i;

  always_comb begin
    inflight_d = inflight_q + CntW'(acc) - CntW'(del);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `AAFT_ASSERT_NEXT(a_stall_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i), "result changed while stalled")
  `AAFT_ASSERT_NOW(a_no_phantom, rsp_valid_i, inflight_q != '0, "result without a pending request")
  `AAFT_ASSERT_NOW(a_depth, 1'b1, inflight_q <= CntW'(PipeDepth), "more requests in flight than stages")
  `AAFT_ASSERT_NOW(a_sat_clip, rsp_valid_i && rsp_data_i.saturated, rsp_data_i.out_x == MaxC || rsp_data_i.out_x == MinC || rsp_data_i.out_y == MaxC || rsp_data_i.out_y == MinC || rsp_data_i.out_z == MaxC || rsp_data_i.out_z == MinC, "saturated flag without a clipped component")

endmodule

bind axis_angle_frame_transform_unit aaft_checker u_aaft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
